@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL; all checks run on i_clk and are off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/pf_pkg.sv @@
package pf_pkg;

    // Operand widths
    localparam int VALUE_W = 32;
    localparam int DIV_W   = 17;
    localparam int CNT_W   = $clog2(VALUE_W);

    // Trial division starts here
    localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(2);

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ sv/pf_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module pf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pf_pkg::VALUE_W-1:0]    i_dividend,
    input  logic [pf_pkg::DIV_W-1:0]      i_divisor,
    output pf_pkg::t_div_stat             o_stat,
    output logic [pf_pkg::VALUE_W-1:0]    o_quot,
    output logic [pf_pkg::DIV_W-1:0]      o_rem
);
    import pf_pkg::*;

    logic [DIV_W-1:0]   r_rem;
    logic [VALUE_W-1:0] r_quo;
    logic [DIV_W-1:0]   r_dsr;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_W:0]     w_shift;
    logic [DIV_W:0]     w_dsr_ext;
    logic               w_ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    assign w_shift   = {r_rem, r_quo[VALUE_W-1]};
    assign w_dsr_ext = {1'b0, r_dsr};
    assign w_ge      = (w_shift >= w_dsr_ext);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend register turns into the quotient as bits shift out.
    // The partial remainder stays below the divisor, so it fits DIV_W bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_W'(w_shift - w_dsr_ext) : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[VALUE_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem;

endmodule

@@ sv/prime_factorizer.sv @@
// Channel   Valid         Stall         Payload
// request   i_in_valid    o_in_stall    i_number[31:0]
// result    o_out_valid   i_out_stall   o_factor[31:0], o_last
//
// Each trial division runs the bit-serial divider in S_DIV and is then judged
// in S_DEC, which starts the next one. A number needs one trial per divisor
// tried plus one per factor found.
// Reset (synchronous, active low) leaves the block idle with no result pending.
// A request is taken only while idle; a pending result may still sit in the
// output register then. A stalled result holds the search at its next factor.
module prime_factorizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pf_pkg::VALUE_W-1:0]    i_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pf_pkg::VALUE_W-1:0]    o_factor,
    output logic                          o_last
);
    import pf_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;

    logic [1:0]         r_state,     n_state;
    logic [VALUE_W-1:0] r_value,     n_value;
    logic [DIV_W-1:0]   r_divisor,   n_divisor;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_factor,    n_factor;
    logic               r_last,      n_last;

    logic               w_start;
    logic [VALUE_W-1:0] w_dividend;
    logic [DIV_W-1:0]   w_divisor;
    t_div_stat          w_div;
    logic [VALUE_W-1:0] w_quot;
    logic [DIV_W-1:0]   w_rem;
    logic               w_out_free;
    logic               w_accept;
    logic               w_fits;
    logic               w_emit;

    pf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    // divisor <= value / divisor
    assign w_fits     = ({{(VALUE_W-DIV_W){1'b0}}, r_divisor} <= w_quot);

    // Sequencer: start a division, then decide factor / next divisor / done
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_divisor   = r_divisor;
        n_factor    = r_factor;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        w_start     = 1'b0;
        w_emit      = 1'b0;
        w_dividend  = r_value;
        w_divisor   = r_divisor;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value    = i_number;
                    n_divisor  = FIRST_DIV;
                    w_dividend = i_number;
                    w_divisor  = FIRST_DIV;
                    w_start    = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (w_fits) begin
                    if (w_rem == '0) begin
                        // exact: emit divisor, keep it, divide the value
                        if (w_out_free) begin
                            w_emit      = 1'b1;
                            n_out_valid = 1'b1;
                            n_factor    = {{(VALUE_W-DIV_W){1'b0}}, r_divisor};
                            n_last      = 1'b0;
                            n_value     = w_quot;
                            w_dividend  = w_quot;
                            w_start     = 1'b1;
                            n_state     = S_DIV;
                        end
                    end else begin
                        n_divisor = DIV_W'(r_divisor + 1'b1);
                        w_divisor = DIV_W'(r_divisor + 1'b1);
                        w_start   = 1'b1;
                        n_state   = S_DIV;
                    end
                end else if (w_out_free) begin
                    // square of divisor exceeds value: cofactor is the last one
                    w_emit      = 1'b1;
                    n_out_valid = 1'b1;
                    n_factor    = r_value;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_divisor   <= FIRST_DIV;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_divisor   <= n_divisor;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_factor <= n_factor;
        r_last   <= n_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_factor    = r_factor;
    assign o_last      = r_last;

    `AST_NOW(a_idle_div_free, r_state == S_IDLE, !w_div.busy)
    `AST_NOW(a_done_in_div, w_div.done, r_state == S_DIV)
    `AST_NOW(a_factor_exact, w_emit && !n_last, w_rem == '0 && w_fits)
    `AST_NEXT(a_start_busy, w_start, w_div.busy)

endmodule

@@ tb/prime_factorizer_checker.sv @@
// Watches both channels of the factorizer, predicts the factor stream for
// every accepted request and checks each accepted result against it.
module prime_factorizer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [pf_pkg::VALUE_W-1:0]    i_number,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [pf_pkg::VALUE_W-1:0]    i_factor,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pf_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] factor;
        logic               last;
    } t_factor_result;

    t_factor_result expected_factors[$];
    int             fail_total;

    assign o_fail_count = fail_total;

    // Append one expected result at the tail of the queue
    task automatic queue_expected(input t_factor_result entry);
        expected_factors.insert(expected_factors.size(), entry);
    endtask

    // Trial division: emit each divisor that divides evenly, keep the same
    // divisor after a hit, finish with the remaining cofactor flagged last.
    task automatic predict_factors(input logic [VALUE_W-1:0] number);
        logic [VALUE_W-1:0] remaining;
        logic [VALUE_W-1:0] divisor;
        int                 found;
        t_factor_result     entry;
        remaining = number;
        divisor   = VALUE_W'(FIRST_DIV);
        found     = 0;
        // divisor <= remaining / divisor is the overflow-free square test
        while (divisor <= remaining / divisor) begin
            if (remaining % divisor == '0) begin
                if (found < VALUE_W - 1) begin
                    entry.factor = divisor;
                    entry.last   = 1'b0;
                    queue_expected(entry);
                    found++;
                end
                remaining = remaining / divisor;
            end else begin
                divisor = divisor + 1'b1;
            end
        end
        // 0 and 1 never enter the loop and come out as themselves
        entry.factor = remaining;
        entry.last   = 1'b1;
        queue_expected(entry);
    endtask

    // Results are compared before the new request is predicted: a result
    // accepted on the same edge always belongs to an earlier request.
    always @(posedge i_clk) begin : monitor
        t_factor_result want;
        if (!i_rst_n) begin
            expected_factors.delete();
            fail_total    = 0;
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_factors.size() == 0) begin
                    $display("%0t: stray result: expected none, actual factor=%0d last=%0b",
                             $time, i_factor, i_last);
                    fail_total++;
                end else begin
                    want = expected_factors.pop_front();
                    if (i_factor !== want.factor) begin
                        $display("%0t: factor mismatch: expected %0d, actual %0d",
                                 $time, want.factor, i_factor);
                        fail_total++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b (factor %0d)",
                                 $time, want.last, i_last, want.factor);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_factors(i_number);
            o_outstanding <= expected_factors.size();
        end
    end

endmodule

@@ tb/tb_prime_factorizer.sv @@
// Drives requests into the factorizer with random gaps and random result
// backpressure; the checker does the prediction, this module the verdict.
module tb_prime_factorizer;
    timeunit 1ns;
    timeprecision 1ps;

    import pf_pkg::*;

    localparam int RANDOM_ITEMS = 83;
    localparam int CALM_ITEMS   = 20;
    localparam int IDLE_LIMIT   = 10_000_000;
    localparam int DRAIN_CYCLES = 100;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [VALUE_W-1:0]  i_number;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [VALUE_W-1:0]  o_factor;
    logic                o_last;

    int                  fail_count;
    int                  outstanding;
    int                  idle_cycles;
    bit                  quiet;

    prime_factorizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_factor    (o_factor),
        .o_last      (o_last)
    );

    prime_factorizer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_number      (i_number),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_factor      (o_factor),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: no request and no result accepted for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result backpressure: stall bursts and free stretches, none once quiet
    initial begin : result_backpressure
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet || $urandom_range(0, 1) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // One request, with an optional idle burst in front; returns on the
    // edge that accepts it, valid still high
    task automatic send_number(input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_number   <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Random numbers kept cheap to factor: every mode bounds the trial
    // divisor near 256.
    function automatic logic [VALUE_W-1:0] random_number();
        logic [63:0] product;
        int          mode;
        int          step;
        int          shift;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            // product of small factors, up to the full 32 bits
            product = 64'd1;
            repeat ($urandom_range(1, 31)) begin
                step = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 13)
                                                   : $urandom_range(2, 255);
                if (product * step <= 64'hFFFF_FFFF)
                    product = product * step;
            end
            return product[VALUE_W-1:0];
        end else if (mode < 7) begin
            return $urandom_range(0, 65535);
        end else begin
            // random high bits over a power of two: odd part below 2^16
            shift = $urandom_range(16, 24);
            return (VALUE_W'($urandom) >> shift) << shift;
        end
    endfunction

    initial begin : stimulus
        int idx;
        quiet      = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_number   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero and one pass straight through
        send_number(32'd0);
        send_number(32'd1);
        // smallest primes and small composites
        send_number(32'd2);
        send_number(32'd3);
        send_number(32'd4);
        send_number(32'd12);
        // squares of primes and of 65535 sit exactly on the square-test bound
        send_number(32'd9);
        send_number(32'd63001);
        send_number(32'hFFFE_0001);
        // primes give a single result
        send_number(32'd65521);
        send_number(32'd65537);
        send_number(32'd1000003);
        // two close primes
        send_number(32'd1022117);
        // longest factor list: 31 twos
        send_number(32'h8000_0000);
        // all ones and alternating patterns
        send_number(32'hFFFF_FFFF);
        send_number(32'hAAAA_AAAA);
        send_number(32'h5555_5555);

        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            if (idx >= RANDOM_ITEMS - CALM_ITEMS)
                quiet = 1'b1;
            send_number(random_number());
        end
        i_in_valid <= 1'b0;

        // wait out every expected result, then a margin for strays
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
